// ----- rtl/core/bsst_pkg.sv -----
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types and constants of the bounded set span tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SET_DEPTH_DEF = 64;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // register index, taken from the upper address bit
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_DUPLICATE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  // what one cell hands to its right-hand neighbour
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               lt_now;
    logic               lt_q;
  } cell_link_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bsst_if.sv -----
// ----------------------------------------------------------------------------
// bsst_if
// Valid/ready channels carrying offered values and per-item results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsst_in_if import bsst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bsst_out_if import bsst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic                span_valid;
  logic [VALUE_W-1:0]  shortest_span;
  logic [VALUE_W-1:0]  longest_span;

  modport source (output valid, output status, output count, output span_valid,
                  output shortest_span, output longest_span, input ready);
  modport sink   (input valid, input status, input count, input span_valid,
                  input shortest_span, input longest_span, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bsst_cell.sv -----
// ----------------------------------------------------------------------------
// bsst_cell
// One slot of the sorted value chain: compares, offers a gap, shifts right.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_cell import bsst_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire cell_link_t         left_i,
  output cell_link_t              right_o,
  output logic                    eq_o,
  output logic                    bnd_o,
  output logic [VALUE_W-1:0]      gap_o
);

  logic [VALUE_W-1:0] value_q, value_d;
  logic               valid_q, valid_d;
  logic               lt_q, eq_q;
  logic [VALUE_W-1:0] gap_q;
  logic               lt_now, eq_now, bnd_now, bnd_q;
  logic [VALUE_W-1:0] lo_gap, hi_gap, gap_now;

  assign lt_now  = valid_q && ($signed(value_q) < $signed(value_i));
  assign eq_now  = valid_q && (value_q == value_i);
  assign bnd_now = left_i.lt_now && !lt_now;
  assign bnd_q   = left_i.lt_q && !lt_q;

  // nearest neighbours sit either side of the insertion point
  assign lo_gap = left_i.valid ? (value_i - left_i.value) : '1;
  assign hi_gap = valid_q ? (value_q - value_i) : '1;

  always_comb begin
    gap_now = (lo_gap < hi_gap) ? lo_gap : hi_gap;
    if (!bnd_now) begin
      gap_now = '0;
    end
  end

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.ins_en && !lt_q) begin
      if (bnd_q) begin
        value_d = value_i;
        valid_d = 1'b1;
      end else begin
        value_d = left_i.value;
        valid_d = left_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        lt_q <= lt_now;
        eq_q <= eq_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctrl_i.cmp_en) begin
      gap_q <= gap_now;
    end
  end

  assign right_o = '{value: value_q, valid: valid_q, lt_now: lt_now, lt_q: lt_q};
  assign eq_o    = eq_q;
  assign bnd_o   = bnd_q;
  assign gap_o   = gap_q;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_set_span_tracker.sv -----
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Bounded set of distinct signed values with shortest gap and longest span.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    value
//   out_o    out  valid/ready    status, count, span_valid, shortest_span,
//                                longest_span
//   apb      in   psel/penable   capacity at byte address 0
//
// each item passes a compare state, which checks every cell of the sorted chain,
// then an update state, which shifts the chain and folds in the gap and extremes
// the next item is taken in the update cycle, while the last one is finishing
// a result waiting in the output register holds the update cycle until taken
// reset empties the chain and sets capacity to 64; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_span_tracker import bsst_pkg::*; #(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bsst_in_if.sink                in_i,
  bsst_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  state_e               state_q, state_d;
  logic [CAP_W-1:0]     cap_q;
  logic [VALUE_W-1:0]   v_q;
  logic [CW-1:0]        count_q, count_d;
  logic [VALUE_W-1:0]   small_q, small_d, large_q, large_d, mgap_q, mgap_d;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic [COUNT_W-1:0]   count_out_q;
  logic                 span_valid_q;
  logic [VALUE_W-1:0]   short_q, long_q;

  cell_ctrl_t           ctrl;
  cell_link_t           head;
  cell_link_t           link [SET_DEPTH];
  logic [SET_DEPTH-1:0] eq_vec, bnd_vec;
  logic [VALUE_W-1:0]   gap_vec [SET_DEPTH];
  logic [VALUE_W-1:0]   gap_any;

  logic slot_free, in_xfer, upd_done, full, dup, do_ins;
  status_e status_d;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // cell chain
  assign head = '{value: '0, valid: 1'b0, lt_now: 1'b1, lt_q: 1'b1};

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    bsst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (v_q),
      .left_i  ((i == 0) ? head : link[(i == 0) ? 0 : i-1]),
      .right_o (link[i]),
      .eq_o    (eq_vec[i]),
      .bnd_o   (bnd_vec[i]),
      .gap_o   (gap_vec[i])
    );
  end

  // only the insertion cell offers a non-zero gap
  always_comb begin
    gap_any = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      gap_any = gap_any | gap_vec[i];
    end
  end

  // control
  assign slot_free = !out_valid_q || out_o.ready;
  assign upd_done  = (state_q == ST_UPD) && slot_free;
  assign in_i.ready = (state_q == ST_IDLE) || upd_done;
  assign in_xfer   = in_i.valid && in_i.ready;

  assign full   = (LW'(count_q) >= LW'(cap_q)) || (count_q >= CW'(SET_DEPTH));
  assign dup    = |eq_vec;
  assign do_ins = !full && !dup;

  assign ctrl.cmp_en = (state_q == ST_CMP);
  assign ctrl.ins_en = upd_done && do_ins;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD: begin
        if (in_xfer) begin
          state_d = ST_CMP;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    small_d  = small_q;
    large_d  = large_q;
    mgap_d   = mgap_q;
    status_d = STATUS_INSERTED;
    priority if (full) begin
      status_d = STATUS_FULL;
    end else if (dup) begin
      status_d = STATUS_DUPLICATE;
    end else begin
      count_d = count_q + 1'b1;
      if (gap_any < mgap_q) begin
        mgap_d = gap_any;
      end
      if (count_q == '0) begin
        small_d = v_q;
        large_d = v_q;
      end else begin
        if ($signed(v_q) < $signed(small_q)) small_d = v_q;
        if ($signed(large_q) < $signed(v_q)) large_d = v_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      small_q     <= '0;
      large_q     <= '0;
      mgap_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_done) begin
        count_q     <= count_d;
        small_q     <= small_d;
        large_q     <= large_d;
        mgap_q      <= mgap_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v_q <= in_i.value;
    end
    if (upd_done) begin
      status_q     <= status_d;
      count_out_q  <= COUNT_W'(count_d);
      span_valid_q <= (count_d >= CW'(2));
      short_q      <= (count_d >= CW'(2)) ? mgap_d : '0;
      long_q       <= (count_d >= CW'(2)) ? (large_d - small_d) : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.count         = count_out_q;
  assign out_o.span_valid    = span_valid_q;
  assign out_o.shortest_span = short_q;
  assign out_o.longest_span  = long_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SET_DEPTH))
    else $error("held count beyond chain depth");

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(eq_vec))
    else $error("value matched in more than one cell");

  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && do_ins |-> $onehot(bnd_vec))
    else $error("insertion point not unique");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(upd_done))
    else $error("count changed outside update cycle");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result raised outside update cycle");
`endif

endmodule

`default_nettype wire
